// File: hw/rtl/frr_pkg.sv
// Package for the framed reply receiver: frame constants, error codes and the result beat type.
package frr_pkg;

   localparam logic [7:0] HDR0         = 8'h46;
   localparam logic [7:0] HDR1         = 8'hB9;
   localparam logic [7:0] HDR2         = 8'h68;
   localparam logic [7:0] HDR3         = 8'h00;
   localparam logic [7:0] END_BYTE     = 8'h16;
   localparam logic [7:0] LEN_OVERHEAD = 8'd6;

   localparam logic [2:0] ERR_HEADER = 3'd0;
   localparam logic [2:0] ERR_LENGTH = 3'd1;
   localparam logic [2:0] ERR_SUM_HI = 3'd2;
   localparam logic [2:0] ERR_SUM_LO = 3'd3;
   localparam logic [2:0] ERR_END    = 3'd4;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic       data_last;
      logic       frame_ok;
      logic       frame_error;
      logic [2:0] error_kind;
      logic [3:0] rx_phase;
   } rsp_type;

endpackage

// File: hw/rtl/frr_parser.sv
// Frame parser: phase, checksum and payload counters, advanced once per byte.
module frr_parser
   import frr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] rx_byte,
   output rsp_type    result
);

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_HDR1    = 4'd1,
      PH_HDR2    = 4'd2,
      PH_HDR3    = 4'd3,
      PH_LEN     = 4'd4,
      PH_PAYLOAD = 4'd5,
      PH_SUM_HI  = 4'd6,
      PH_SUM_LO  = 4'd7,
      PH_END     = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  index_ff, index_in;
   logic        go_hunt;

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      index_in = index_ff;
      go_hunt  = 1'b0;
      result   = '0;
      unique case (phase_ff)
         PH_HDR1: begin
            if (rx_byte == HDR1) begin
               phase_in = PH_HDR2;
            end else begin
               go_hunt            = 1'b1;
               result.frame_error = 1'b1;
               result.error_kind  = ERR_HEADER;
            end
         end
         PH_HDR2: begin
            if (rx_byte == HDR2) begin
               phase_in = PH_HDR3;
            end else begin
               go_hunt            = 1'b1;
               result.frame_error = 1'b1;
               result.error_kind  = ERR_HEADER;
            end
         end
         PH_HDR3: begin
            if (rx_byte == HDR3) begin
               phase_in = PH_LEN;
            end else begin
               go_hunt            = 1'b1;
               result.frame_error = 1'b1;
               result.error_kind  = ERR_HEADER;
            end
         end
         PH_LEN: begin
            if (rx_byte < LEN_OVERHEAD) begin
               go_hunt            = 1'b1;
               result.frame_error = 1'b1;
               result.error_kind  = ERR_LENGTH;
            end else begin
               sum_in   = {8'd0, HDR2} + {8'd0, rx_byte};
               count_in = rx_byte - LEN_OVERHEAD;
               index_in = '0;
               phase_in = (rx_byte == LEN_OVERHEAD) ? PH_SUM_HI : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_in            = sum_ff + {8'd0, rx_byte};
            index_in          = index_ff + 8'd1;
            result.data_valid = 1'b1;
            result.data_byte  = rx_byte;
            if (index_in == count_ff) begin
               result.data_last = 1'b1;
               phase_in         = PH_SUM_HI;
            end
         end
         PH_SUM_HI: begin
            if (rx_byte == sum_ff[15:8]) begin
               phase_in = PH_SUM_LO;
            end else begin
               go_hunt            = 1'b1;
               result.frame_error = 1'b1;
               result.error_kind  = ERR_SUM_HI;
            end
         end
         PH_SUM_LO: begin
            if (rx_byte == sum_ff[7:0]) begin
               phase_in = PH_END;
            end else begin
               go_hunt            = 1'b1;
               result.frame_error = 1'b1;
               result.error_kind  = ERR_SUM_LO;
            end
         end
         PH_END: begin
            go_hunt = 1'b1;
            if (rx_byte == END_BYTE) begin
               result.frame_ok = 1'b1;
            end else begin
               result.frame_error = 1'b1;
               result.error_kind  = ERR_END;
            end
         end
         default: begin
            go_hunt = 1'b1;
         end
      endcase
      if (go_hunt) begin
         sum_in   = '0;
         count_in = '0;
         index_in = '0;
         // a start byte opens a frame only from the hunt or from an undefined phase
         phase_in = (phase_ff == PH_HUNT && rx_byte == HDR0) ? PH_HDR1 : PH_HUNT;
         if (!(phase_ff == PH_HUNT || phase_ff == PH_HDR1 || phase_ff == PH_HDR2 ||
               phase_ff == PH_HDR3 || phase_ff == PH_LEN || phase_ff == PH_PAYLOAD ||
               phase_ff == PH_SUM_HI || phase_ff == PH_SUM_LO || phase_ff == PH_END) &&
             rx_byte == HDR0) begin
            phase_in = PH_HDR1;
         end
      end
      result.rx_phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         count_ff <= '0;
         index_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   a_reset_hunt: assert property (@(posedge clock)
      reset |=> phase_ff == PH_HUNT && sum_ff == 16'd0)
      else $error("parser not in hunt after reset");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> index_ff < count_ff)
      else $error("payload index ran past count");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && (result.frame_ok || result.frame_error) |=>
         sum_ff == 16'd0 && count_ff == 8'd0 && index_ff == 8'd0)
      else $error("counters not cleared on frame end");

endmodule

// File: hw/rtl/frr_rsp_reg.sv
// Result register: holds one result beat until the consumer takes it.
module frr_rsp_reg
   import frr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    can_load
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load  = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// File: hw/rtl/framed_reply_receiver.sv
// Top level of the framed reply receiver: input register, parser and result register.
//
//   channel   dir   ports                                   beat
//   req       in    req_valid, req_stall, req_rx_byte       one received byte
//   rsp       out   rsp_valid, rsp_stall, rsp_data_valid..  one result per byte
//
// One byte per cycle sustained while rsp is not stalled.
// Input register, then the parser step, then the result register.
// Synchronous reset puts the parser in the hunt and empties both registers.
// A stall on rsp backs up through the input register to req_stall the same cycle.
module framed_reply_receiver
   import frr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_data_valid,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_data_last,
   output logic       rsp_frame_ok,
   output logic       rsp_frame_error,
   output logic [2:0] rsp_error_kind,
   output logic [3:0] rsp_rx_phase
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       can_load;
   logic       advance;
   logic       req_take;
   rsp_type    step_result;
   rsp_type    rsp_data;

   assign advance     = in_valid_ff && can_load;
   assign req_stall   = in_valid_ff && !can_load;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   frr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   frr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (step_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .can_load  (can_load)
   );

   assign rsp_data_valid  = rsp_data.data_valid;
   assign rsp_data_byte   = rsp_data.data_byte;
   assign rsp_data_last   = rsp_data.data_last;
   assign rsp_frame_ok    = rsp_data.frame_ok;
   assign rsp_frame_error = rsp_data.frame_error;
   assign rsp_error_kind  = rsp_data.error_kind;
   assign rsp_rx_phase    = rsp_data.rx_phase;

endmodule

// File: verif/tb_framed_reply_receiver.sv
// Testbench for framed_reply_receiver: directed and random byte streams checked beat by beat.
`timescale 1ns / 1ps

module tb_framed_reply_receiver;
   import frr_pkg::*;

   localparam int ITEM_TARGET = 1700;
   localparam int CALM_AFTER = 1450;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [2:0] NO_ERROR = 3'd0;

   typedef enum logic [3:0] {
      PH_HUNT, PH_HDR1, PH_HDR2, PH_HDR3, PH_LEN,
      PH_PAYLOAD, PH_SUM_HI, PH_SUM_LO, PH_END
   } phase_type;

   typedef struct {
      logic [7:0] rx;
      bit         fixed;
      rsp_type    want;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_data_valid;
   logic [7:0] rsp_data_byte;
   logic       rsp_data_last;
   logic       rsp_frame_ok;
   logic       rsp_frame_error;
   logic [2:0] rsp_error_kind;
   logic [3:0] rsp_rx_phase;

   // receiver model state
   logic [3:0]  rx_state = PH_HUNT;
   logic [15:0] frame_sum = '0;
   logic [7:0]  frame_len = '0;
   logic [7:0]  frame_pos = '0;

   rsp_type      expected_results[$];
   stim_row_type directed_rows[$];
   int           mismatches = 0;
   int           bytes_sent = 0;
   int           frames_ok = 0;
   int           frames_bad = 0;
   int           payload_beats = 0;
   bit           calm = 1'b0;
   bit           steady = 1'b0;
   rsp_type      seen;
   rsp_type      wanted;

   framed_reply_receiver i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_data_last   (rsp_data_last),
      .rsp_frame_ok    (rsp_frame_ok),
      .rsp_frame_error (rsp_frame_error),
      .rsp_error_kind  (rsp_error_kind),
      .rsp_rx_phase    (rsp_rx_phase)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic rsp_type parse_byte(input logic [7:0] b);
      rsp_type    r;
      logic       restart;
      logic [3:0] restart_to;
      logic [7:0] hdr_want;
      r = '0;
      restart = 1'b0;
      restart_to = PH_HUNT;
      case (rx_state)
         PH_HDR1, PH_HDR2, PH_HDR3: begin
            hdr_want = (rx_state == PH_HDR1) ? HDR1 : (rx_state == PH_HDR2) ? HDR2 : HDR3;
            if (b == hdr_want) begin
               rx_state = rx_state + 4'd1;
            end else begin
               r.frame_error = 1'b1;
               r.error_kind = ERR_HEADER;
               restart = 1'b1;
            end
         end
         PH_LEN: begin
            if (b < LEN_OVERHEAD) begin
               r.frame_error = 1'b1;
               r.error_kind = ERR_LENGTH;
               restart = 1'b1;
            end else begin
               frame_sum = {8'h00, HDR2} + {8'h00, b};
               frame_len = b - LEN_OVERHEAD;
               frame_pos = '0;
               rx_state = (frame_len == 0) ? PH_SUM_HI : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            frame_sum = frame_sum + {8'h00, b};
            frame_pos = frame_pos + 8'd1;
            r.data_valid = 1'b1;
            r.data_byte = b;
            if (frame_pos == frame_len) begin
               r.data_last = 1'b1;
               rx_state = PH_SUM_HI;
            end
         end
         PH_SUM_HI: begin
            if (b == frame_sum[15:8]) begin
               rx_state = PH_SUM_LO;
            end else begin
               r.frame_error = 1'b1;
               r.error_kind = ERR_SUM_HI;
               restart = 1'b1;
            end
         end
         PH_SUM_LO: begin
            if (b == frame_sum[7:0]) begin
               rx_state = PH_END;
            end else begin
               r.frame_error = 1'b1;
               r.error_kind = ERR_SUM_LO;
               restart = 1'b1;
            end
         end
         PH_END: begin
            if (b == END_BYTE) begin
               r.frame_ok = 1'b1;
            end else begin
               r.frame_error = 1'b1;
               r.error_kind = ERR_END;
            end
            restart = 1'b1;
         end
         default: begin
            restart = 1'b1;
            restart_to = (b == HDR0) ? PH_HDR1 : PH_HUNT;
         end
      endcase
      if (restart) begin
         rx_state = restart_to;
         frame_sum = '0;
         frame_len = '0;
         frame_pos = '0;
      end
      r.rx_phase = rx_state;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
   endtask

   task automatic add_row(input logic [7:0] rx, input bit fixed, input rsp_type want);
      stim_row_type row;
      row.rx = rx;
      row.fixed = fixed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // one input beat: optional gap, then hold until taken
   task automatic send_byte(input logic [7:0] b, input bit fixed, input rsp_type want);
      rsp_type predicted;
      if (!calm && !steady && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      predicted = parse_byte(b);
      expected_results.push_back(fixed ? want : predicted);
      bytes_sent++;
      frames_ok += predicted.frame_ok;
      frames_bad += predicted.frame_error;
      payload_beats += predicted.data_valid;
   endtask

   task automatic send_frame();
      logic [7:0]  frame_bytes[$];
      logic [7:0]  len;
      logic [7:0]  b;
      logic [15:0] sum;
      int          roll;
      int          i;
      int          spot;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         len = 8'($urandom_range(200, 255));
      else if (roll < 10)
         len = 8'($urandom_range(0, 5));
      else
         len = 8'($urandom_range(6, 24));
      frame_bytes = '{HDR0, HDR1, HDR2, HDR3, len};
      sum = {8'h00, HDR2} + {8'h00, len};
      if (len >= LEN_OVERHEAD) begin
         for (i = 0; i < len - LEN_OVERHEAD; i++) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            sum = sum + {8'h00, b};
         end
         frame_bytes.push_back(sum[15:8]);
         frame_bytes.push_back(sum[7:0]);
         frame_bytes.push_back(END_BYTE);
      end
      if ($urandom_range(0, 99) < 15) begin
         spot = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[spot] = frame_bytes[spot] ^ 8'($urandom_range(1, 255));
      end
      steady = ($urandom_range(0, 3) == 0);
      foreach (frame_bytes[j])
         send_byte(frame_bytes[j], 1'b0, '0);
      steady = 1'b0;
   endtask

   // result side stall bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 11) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_data_valid, rsp_data_byte, rsp_data_last, rsp_frame_ok,
                 rsp_frame_error, rsp_error_kind, rsp_rx_phase};
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", seen, 0);
         end else begin
            wanted = expected_results.pop_front();
            if (seen.data_valid !== wanted.data_valid)
               report_mismatch("data_valid", seen.data_valid, wanted.data_valid);
            if (seen.data_byte !== wanted.data_byte)
               report_mismatch("data_byte", seen.data_byte, wanted.data_byte);
            if (seen.data_last !== wanted.data_last)
               report_mismatch("data_last", seen.data_last, wanted.data_last);
            if (seen.frame_ok !== wanted.frame_ok)
               report_mismatch("frame_ok", seen.frame_ok, wanted.frame_ok);
            if (seen.frame_error !== wanted.frame_error)
               report_mismatch("frame_error", seen.frame_error, wanted.frame_error);
            if (seen.error_kind !== wanted.error_kind)
               report_mismatch("error_kind", seen.error_kind, wanted.error_kind);
            if (seen.rx_phase !== wanted.rx_phase)
               report_mismatch("rx_phase", seen.rx_phase, wanted.rx_phase);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_results.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      bit mid_pause_done;
      int noise;
      mid_pause_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;

      // noise, header mismatch, short length, empty payload, one-byte payload, bad end
      add_row(8'h00, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_ERROR, PH_HUNT});
      add_row(HDR0, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_ERROR, PH_HDR1});
      add_row(HDR0, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ERR_HEADER, PH_HUNT});
      add_row(HDR0, 1'b0, '0);
      add_row(HDR1, 1'b0, '0);
      add_row(HDR2, 1'b0, '0);
      add_row(HDR3, 1'b0, '0);
      add_row(8'h05, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ERR_LENGTH, PH_HUNT});
      add_row(HDR0, 1'b0, '0);
      add_row(HDR1, 1'b0, '0);
      add_row(HDR2, 1'b0, '0);
      add_row(HDR3, 1'b0, '0);
      add_row(8'h06, 1'b0, '0);
      add_row(8'h00, 1'b0, '0);
      add_row(8'h6E, 1'b0, '0);
      add_row(END_BYTE, 1'b1, {1'b0, 8'h00, 1'b0, 1'b1, 1'b0, NO_ERROR, PH_HUNT});
      add_row(HDR0, 1'b0, '0);
      add_row(HDR1, 1'b0, '0);
      add_row(HDR2, 1'b0, '0);
      add_row(HDR3, 1'b0, '0);
      add_row(8'h07, 1'b0, '0);
      add_row(8'hFF, 1'b1, {1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, NO_ERROR, PH_SUM_HI});
      add_row(8'h01, 1'b0, '0);
      add_row(8'h6E, 1'b0, '0);
      add_row(8'hFF, 1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 1'b1, ERR_END, PH_HUNT});

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k])
         send_byte(directed_rows[k].rx, directed_rows[k].fixed, directed_rows[k].want);

      // hold off until the pipeline is empty
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);

      while (bytes_sent < ITEM_TARGET) begin
         if (!mid_pause_done && bytes_sent > ITEM_TARGET / 2) begin
            mid_pause_done = 1'b1;
            req_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clock);
         end
         calm = (bytes_sent >= CALM_AFTER);
         if ($urandom_range(0, 3) == 0) begin
            noise = $urandom_range(1, 4);
            repeat (noise) send_byte(8'($urandom), 1'b0, '0);
         end
         send_frame();
      end

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d bytes: %0d frames completed, %0d frames abandoned, %0d payload beats",
               bytes_sent, frames_ok, frames_bad, payload_beats);
      $display("random and stalled traffic on both sides, %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
